// ----- hdl/psfs_pkg.sv -----
// Package for the PCM sample frame serializer.
// Holds the queue entry type, header constants and byte index codes.
// No dependencies.
`default_nettype none

package psfs_pkg;

  localparam logic [15:0] BLOCK_SAMPLES_RESET = 16'd160;

  localparam logic [7:0] SYNC0 = 8'hAA;
  localparam logic [7:0] SYNC1 = 8'h55;
  localparam logic [7:0] SYNC2 = 8'hA5;
  localparam logic [7:0] SYNC3 = 8'h5A;

  typedef logic [3:0] byte_idx_t;

  localparam byte_idx_t BYTE_SYNC0    = 4'd0;
  localparam byte_idx_t BYTE_SYNC1    = 4'd1;
  localparam byte_idx_t BYTE_SYNC2    = 4'd2;
  localparam byte_idx_t BYTE_SYNC3    = 4'd3;
  localparam byte_idx_t BYTE_FRAME_LO = 4'd4;
  localparam byte_idx_t BYTE_FRAME_HI = 4'd5;
  localparam byte_idx_t BYTE_COUNT_LO = 4'd6;
  localparam byte_idx_t BYTE_COUNT_HI = 4'd7;
  localparam byte_idx_t BYTE_PCM_LO   = 4'd8;
  localparam byte_idx_t BYTE_PCM_HI   = 4'd9;

  typedef struct packed {
    logic        hdr;
    logic [15:0] frame_cnt;
    logic [15:0] blk_cnt;
    logic [15:0] pcm;
  } desc_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

`default_nettype wire

// ----- hdl/psfs_front.sv -----
// Front part of the serializer: accepts raw words, tracks block position
// and frame counter, and builds one queue entry per transfer. Uses psfs_pkg.
`default_nettype none

module psfs_front (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_wr_en,
  input  wire logic [15:0]          cfg_wr_data,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [31:0]          in_raw_sample,
  input  wire psfs_pkg::q_status_t  q_status,
  output logic                      push,
  output psfs_pkg::desc_t           push_desc
);
  import psfs_pkg::*;

  logic [15:0] blk_r;
  logic [15:0] pos_r;
  logic [15:0] pos_nxt;
  logic [15:0] frame_cnt_r;
  logic [15:0] frame_cnt_nxt;
  logic [16:0] next_pos;
  logic        start;

  assign in_stall = q_status.full;
  assign push     = in_valid && !q_status.full;
  assign start    = (pos_r == 16'd0);
  assign next_pos = {1'b0, pos_r} + 17'd1;

  always_comb begin
    push_desc.hdr       = start;
    push_desc.frame_cnt = frame_cnt_r;
    push_desc.blk_cnt   = blk_r;
    push_desc.pcm       = in_raw_sample[31:16];
    pos_nxt             = pos_r;
    frame_cnt_nxt       = frame_cnt_r;
    if (push) begin
      if (next_pos >= {1'b0, blk_r}) begin
        pos_nxt = 16'd0;
      end else begin
        pos_nxt = next_pos[15:0];
      end
      if (start) begin
        frame_cnt_nxt = frame_cnt_r + 16'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blk_r       <= BLOCK_SAMPLES_RESET;
      pos_r       <= 16'd0;
      frame_cnt_r <= 16'd0;
    end else begin
      if (cfg_wr_en) begin
        blk_r <= cfg_wr_data;
      end
      pos_r       <= pos_nxt;
      frame_cnt_r <= frame_cnt_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/psfs_queue.sv -----
// Short FIFO between the front and back parts of the serializer.
// Stores psfs_pkg::desc_t entries; depth set by DEPTH.
`default_nettype none

module psfs_queue #(
  parameter int DEPTH = 2
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 push,
  input  wire psfs_pkg::desc_t      push_desc,
  input  wire logic                 pop,
  output psfs_pkg::desc_t           head_desc,
  output psfs_pkg::q_status_t       q_status
);
  import psfs_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  desc_t         mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r;
  logic [PW-1:0] rd_ptr_r;
  logic [CW-1:0] cnt_r;
  logic          do_push;
  logic          do_pop;

  assign q_status.full  = (cnt_r == FULL_CNT);
  assign q_status.empty = (cnt_r == '0);
  assign do_push        = push && !q_status.full;
  assign do_pop         = pop && !q_status.empty;
  assign head_desc      = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ----- hdl/psfs_back.sv -----
// Back part of the serializer: takes queue entries and emits their bytes,
// header first when flagged, through an output register. Uses psfs_pkg.
`default_nettype none

module psfs_back (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire psfs_pkg::desc_t      head_desc,
  input  wire psfs_pkg::q_status_t  q_status,
  output logic                      pop,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [7:0]                out_byte,
  output logic                      out_is_header,
  output logic                      out_last_of_run
);
  import psfs_pkg::*;

  desc_t     desc_r;
  byte_idx_t idx_r;
  logic      busy_r;
  logic      out_valid_r;
  logic [7:0] byte_r;
  logic      hdr_r;
  logic      last_r;
  logic      adv;
  logic      at_last;
  logic [7:0] cur_byte;

  assign adv       = busy_r && (!out_valid_r || !out_stall);
  assign at_last   = (idx_r == BYTE_PCM_HI);
  assign pop       = (!busy_r || (adv && at_last)) && !q_status.empty;

  assign out_valid       = out_valid_r;
  assign out_byte        = byte_r;
  assign out_is_header   = hdr_r;
  assign out_last_of_run = last_r;

  always_comb begin
    case (idx_r)
      BYTE_SYNC0:    cur_byte = SYNC0;
      BYTE_SYNC1:    cur_byte = SYNC1;
      BYTE_SYNC2:    cur_byte = SYNC2;
      BYTE_SYNC3:    cur_byte = SYNC3;
      BYTE_FRAME_LO: cur_byte = desc_r.frame_cnt[7:0];
      BYTE_FRAME_HI: cur_byte = desc_r.frame_cnt[15:8];
      BYTE_COUNT_LO: cur_byte = desc_r.blk_cnt[7:0];
      BYTE_COUNT_HI: cur_byte = desc_r.blk_cnt[15:8];
      BYTE_PCM_LO:   cur_byte = desc_r.pcm[7:0];
      BYTE_PCM_HI:   cur_byte = desc_r.pcm[15:8];
      default:       cur_byte = 8'h00;
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      byte_r <= cur_byte;
      hdr_r  <= (idx_r < BYTE_PCM_LO);
      last_r <= at_last;
    end
    if (pop) begin
      desc_r <= head_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      idx_r       <= BYTE_SYNC0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (pop) begin
        busy_r <= 1'b1;
        idx_r  <= head_desc.hdr ? BYTE_SYNC0 : BYTE_PCM_LO;
      end else if (adv) begin
        if (at_last) begin
          busy_r <= 1'b0;
        end else begin
          idx_r <= idx_r + 4'd1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ----- hdl/pcm_sample_frame_serializer.sv -----
// A sample's first byte is registered in the queue, then in desc_r and byte_r.
// The single output register emits one byte per cycle unless stalled; a sample
// is 2 bytes, or 10 when it opens a block with its 8-byte header.
// Input transfers continue while the entry queue has room.
// Synchronous active-low reset empties the queue, clears the frame counter and
// block position, and restores the block size to 160.
`default_nettype none

module pcm_sample_frame_serializer #(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [15:0] cfg_wr_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [31:0] in_raw_sample,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_byte,
  output logic             out_is_header,
  output logic             out_last_of_run
);
  import psfs_pkg::*;

  q_status_t q_status;
  desc_t     push_desc;
  desc_t     head_desc;
  logic      push;
  logic      pop;

  psfs_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_raw_sample (in_raw_sample),
    .q_status      (q_status),
    .push          (push),
    .push_desc     (push_desc)
  );

  psfs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_desc (push_desc),
    .pop       (pop),
    .head_desc (head_desc),
    .q_status  (q_status)
  );

  psfs_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head_desc       (head_desc),
    .q_status        (q_status),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte        (out_byte),
    .out_is_header   (out_is_header),
    .out_last_of_run (out_last_of_run)
  );

endmodule

`default_nettype wire

// ----- hdl/psfs_checker.sv -----
// Port-level checks for the PCM sample frame serializer.
// Bound to pcm_sample_frame_serializer; no package needed.
`default_nettype none

module psfs_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [7:0] out_byte,
  input wire logic       out_is_header,
  input wire logic       out_last_of_run
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_byte))
    else $error("Stalled output transfer changed.");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("Output valid after reset.");

  a_last_payload: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_of_run |-> !out_is_header)
    else $error("Last byte of a run marked as header.");

  a_header_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_is_header |=> out_valid || !$past(out_valid))
    else $error("Header transfer not followed by more bytes.");

endmodule

bind pcm_sample_frame_serializer psfs_checker u_psfs_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_byte        (out_byte),
  .out_is_header   (out_is_header),
  .out_last_of_run (out_last_of_run)
);

`default_nettype wire

// ----- bench/pcm_sample_frame_serializer_tb.sv -----
// Testbench for pcm_sample_frame_serializer: directed and random sample streams
// are checked byte by byte against a built-in frame predictor.
// Depends on psfs_pkg and the serializer RTL only.
`timescale 1ns / 100ps

module pcm_sample_frame_serializer_tb;
  import psfs_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       hdr;
    logic       last;
  } framed_byte_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] in_raw_sample = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_byte;
  logic        out_is_header;
  logic        out_last_of_run;

  framed_byte_t pending_bytes[$];
  logic [15:0]  block_len = BLOCK_SAMPLES_RESET;
  logic [15:0]  next_frame_no = '0;
  logic [15:0]  samples_in_block = '0;
  bit           calm = 1'b0;
  int           errors = 0;

  pcm_sample_frame_serializer uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_raw_sample  (in_raw_sample),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .out_is_header  (out_is_header),
    .out_last_of_run(out_last_of_run)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #5ms;
    $display("simulation failed");
    $finish;
  end

  function automatic void push_byte(input logic [7:0] data, input logic hdr,
                                    input logic last);
    framed_byte_t b;
    b.data = data;
    b.hdr  = hdr;
    b.last = last;
    pending_bytes.push_back(b);
  endfunction

  function automatic void frame_sample(input logic [31:0] word);
    logic [15:0] pcm;
    pcm = word[31:16];
    if (samples_in_block == 16'd0) begin
      push_byte(SYNC0, 1'b1, 1'b0);
      push_byte(SYNC1, 1'b1, 1'b0);
      push_byte(SYNC2, 1'b1, 1'b0);
      push_byte(SYNC3, 1'b1, 1'b0);
      push_byte(next_frame_no[7:0], 1'b1, 1'b0);
      push_byte(next_frame_no[15:8], 1'b1, 1'b0);
      push_byte(block_len[7:0], 1'b1, 1'b0);
      push_byte(block_len[15:8], 1'b1, 1'b0);
      next_frame_no = next_frame_no + 16'd1;
    end
    push_byte(pcm[7:0], 1'b0, 1'b0);
    push_byte(pcm[15:8], 1'b0, 1'b1);
    if ({1'b0, samples_in_block} + 17'd1 >= {1'b0, block_len})
      samples_in_block = 16'd0;
    else
      samples_in_block = samples_in_block + 16'd1;
  endfunction

  // Result side: check every accepted byte and stall at random.
  always @(posedge clk) begin
    framed_byte_t exp_b;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_bytes.size() == 0) begin
        $display("%0t: unexpected byte, got %h hdr %b last %b", $time, out_byte,
                 out_is_header, out_last_of_run);
        errors++;
      end else begin
        exp_b = pending_bytes.pop_front();
        if (out_byte !== exp_b.data) begin
          $display("%0t: out_byte expected %h, actual %h", $time, exp_b.data, out_byte);
          errors++;
        end
        if (out_is_header !== exp_b.hdr) begin
          $display("%0t: out_is_header expected %b, actual %b", $time, exp_b.hdr,
                   out_is_header);
          errors++;
        end
        if (out_last_of_run !== exp_b.last) begin
          $display("%0t: out_last_of_run expected %b, actual %b", $time, exp_b.last,
                   out_last_of_run);
          errors++;
        end
      end
    end
    out_stall <= !calm && ($urandom_range(99) < 30);
  end

  task automatic send_sample(input logic [31:0] word);
    while (!calm && $urandom_range(99) < 30) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_raw_sample <= word;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    frame_sample(word);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_block_len(input logic [15:0] len);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= len;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    block_len = len;
  endtask

  task automatic test_reset_size;
    send_sample(32'h0000_0000);
    send_sample(32'hFFFF_FFFF);
    send_sample(32'h7FFF_0000);
    send_sample(32'h8000_0000);
    send_sample(32'h0000_FFFF);
    send_sample(32'h1234_5678);
    send_sample(32'hA5A5_5A5A);
    send_sample(32'h55AA_AA55);
    drain();
  endtask

  task automatic test_single_sample_blocks;
    write_block_len(16'd1);
    repeat (4) send_sample($urandom);
    drain();
  endtask

  task automatic test_zero_block_size;
    write_block_len(16'd0);
    repeat (3) send_sample($urandom);
    drain();
  endtask

  task automatic test_max_block_size;
    write_block_len(16'hFFFF);
    repeat (3) send_sample($urandom);
    drain();
  endtask

  // Shrinking the block below its current fill ends it on the next transfer.
  task automatic test_resize_mid_block;
    write_block_len(16'd8);
    repeat (5) send_sample($urandom);
    drain();
    write_block_len(16'd3);
    repeat (3) send_sample($urandom);
    drain();
  endtask

  task automatic test_random_blocks;
    int pick;
    int count;
    for (int phase = 0; phase < 16; phase++) begin
      pick = $urandom_range(9);
      if (pick == 0)
        write_block_len(16'($urandom_range(1000, 65535)));
      else if (pick == 1)
        write_block_len(16'd1);
      else
        write_block_len(16'($urandom_range(2, 12)));
      count = $urandom_range(10, 30);
      repeat (count) send_sample($urandom);
      drain();
    end
  endtask

  task automatic test_back_to_back;
    calm = 1'b1;
    write_block_len(16'($urandom_range(2, 6)));
    repeat (70) send_sample($urandom);
    drain();
    calm = 1'b0;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_size();
    test_single_sample_blocks();
    test_zero_block_size();
    test_max_block_size();
    test_resize_mid_block();
    test_random_blocks();
    test_back_to_back();
    repeat (20) @(posedge clk);
    if (errors == 0 && pending_bytes.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hdl/psfs_pkg.sv
hdl/psfs_front.sv
hdl/psfs_queue.sv
hdl/psfs_back.sv
hdl/pcm_sample_frame_serializer.sv
hdl/psfs_checker.sv
bench/pcm_sample_frame_serializer_tb.sv
